/* design/spd_pkg.sv */
package spd_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_GAMMA  = 3'd0;
    localparam logic [2:0] REG_ALPHA  = 3'd1;
    localparam logic [2:0] REG_LAMBDA = 3'd2;
    localparam logic [2:0] REG_VACUUM = 3'd3;
    localparam logic [2:0] REG_TCRIT  = 3'd4;
    localparam logic [2:0] REG_RECIP  = 3'd5;
    localparam logic [2:0] REG_MODE   = 3'd6;

    localparam logic signed [31:0] Q_ONE     = 32'sd65536;
    localparam logic signed [31:0] Q_HALF    = 32'sd32768;
    localparam logic signed [31:0] Q_THIRD   = 32'sd21845;
    localparam logic signed [31:0] Q_QUARTER = 32'sd16384;
    localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [35:0] Q_THREE   = 36'sd196608;
    localparam logic signed [35:0] Q_SIX     = 36'sd393216;

    localparam logic signed [63:0] SAT_HI   = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO   = -64'sd2147483648;
    localparam logic signed [63:0] RND_HALF = 64'sd32768;

    typedef struct packed {
        logic              ovf;
        logic signed [31:0] val;
    } t_qres;

    function automatic logic signed [63:0] qprod(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return a * b;
    endfunction

    function automatic t_qres qsat(input logic signed [63:0] s);
        t_qres r;
        if (s > SAT_HI) begin
            r.ovf = 1'b1;
            r.val = Q_MAX;
        end else if (s < SAT_LO) begin
            r.ovf = 1'b1;
            r.val = Q_MIN;
        end else begin
            r.ovf = 1'b0;
            r.val = s[31:0];
        end
        return r;
    endfunction

    // round to nearest, ties toward +inf, then clamp
    function automatic t_qres qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + RND_HALF) >>> 16;
        return qsat(s);
    endfunction

endpackage

/* design/spd_in_if.sv */
interface spd_in_if;
    import spd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] temperature;
    logic signed [DATA_W-1:0] field_value;

    modport source (output valid, output temperature, output field_value, input ready);
    modport sink   (input valid, input temperature, input field_value, output ready);

endinterface

/* design/spd_out_if.sv */
interface spd_out_if;
    import spd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] potential;
    logic signed [DATA_W-1:0] d_field;
    logic signed [DATA_W-1:0] d_temp;
    logic signed [DATA_W-1:0] d2_temp;
    logic                     overflow;

    modport source (output valid, output potential, output d_field, output d_temp,
                    output d2_temp, output overflow, input ready);
    modport sink   (input valid, input potential, input d_field, input d_temp,
                    input d2_temp, input overflow, output ready);

endinterface

/* design/scalar_potential_and_derivatives_top.sv */
// Quartic scalar potential V(phi,T) with dV/dphi, dV/dT and d2V/dT2 for one lattice
// site per transaction, in signed Q16.16 with saturation; overflow flags any clamped
// step of the selected model (thermal polynomial or bag, chosen by the mode register).
// One site is accepted every clock cycle while a stalled output does not hold the stages;
// a site's result passes through five dependent multiply levels (each a 32x32 product
// register followed by a round-and-saturate register), one clamp stage between the first
// two levels and a final sum-and-select stage that is also the output register. Each
// stage advances on its own, so bubbles are filled while a result waits at the output.
// Registers sit on the APB port at byte addresses 0x00 gamma, 0x04 alpha, 0x08 lambda,
// 0x0C vacuum offset V0, 0x10 critical temperature T0, 0x14 reciprocal of phi_0,
// 0x18 mode (bit 0: 1 selects the bag model); write them only while no site is in flight.
module scalar_potential_and_derivatives_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spd_pkg::ADDR_W-1:0]  paddr,
    input  logic [spd_pkg::DATA_W-1:0]  pwdata,
    output logic [spd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    spd_in_if.sink                      i_in,
    spd_out_if.source                   o_out
);
    import spd_pkg::*;

    localparam int NST = 12;

    localparam int P1_T2 = 0, P1_T02 = 1, P1_P2 = 2, P1_AT = 3, P1_GT = 4,
                   P1_X = 5, P1_GPHI = 6, N1 = 7;
    localparam int P2_G = 0, P2_P3 = 1, P2_P4 = 2, P2_GP2 = 3, P2_ATP2 = 4,
                   P2_GTP2 = 5, P2_AP2 = 6, P2_T3 = 7, P2_T4 = 8, P2_X2 = 9,
                   P2_XR = 10, N2 = 11;
    localparam int P3_GP2M = 0, P3_ATP3 = 1, P3_LP4 = 2, P3_LP3 = 3, P3_AP3 = 4,
                   P3_GPHIT = 5, P3_VX2 = 6, P3_VXR = 7, N3 = 8;
    localparam int P4_HTH = 0, P4_THTH = 1, P4_QU = 2, P4_HBAG = 3, P4_AP3T = 4,
                   P4_A = 5, P4_B = 6, N4 = 7;
    localparam int P5_AT4 = 0, P5_BT4 = 1, P5_T3A = 2, P5_T2A = 3, N5 = 4;

    localparam logic [N1-1:0] TH1 = 7'b0011111, BAG1 = 7'b1100101;
    localparam logic [N2-1:0] TH2 = 11'b00000111111, BAG2 = 11'b11111001110;
    localparam logic [N3-1:0] TH3 = 8'b00111111, BAG3 = 8'b11011100;
    localparam logic [N4-1:0] TH4 = 7'b0010111, BAG4 = 7'b1111100;

    logic signed [31:0] r_gamma, r_alpha, r_lambda, r_vacuum, r_tcrit, r_recip;
    logic               r_bag_model;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;
    logic [10:1]    r_ovt, r_ovb;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma     <= '0;
            r_alpha     <= '0;
            r_lambda    <= '0;
            r_vacuum    <= '0;
            r_tcrit     <= '0;
            r_recip     <= Q_ONE;
            r_bag_model <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
                REG_GAMMA:  r_gamma     <= pwdata;
                REG_ALPHA:  r_alpha     <= pwdata;
                REG_LAMBDA: r_lambda    <= pwdata;
                REG_VACUUM: r_vacuum    <= pwdata;
                REG_TCRIT:  r_tcrit     <= pwdata;
                REG_RECIP:  r_recip     <= pwdata;
                REG_MODE:   r_bag_model <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_GAMMA:  prdata = r_gamma;
            REG_ALPHA:  prdata = r_alpha;
            REG_LAMBDA: prdata = r_lambda;
            REG_VACUUM: prdata = r_vacuum;
            REG_TCRIT:  prdata = r_tcrit;
            REG_RECIP:  prdata = r_recip;
            REG_MODE:   prdata = {{(DATA_W-1){1'b0}}, r_bag_model};
            default:    prdata = '0;
        endcase
    end

    // stage advance: a stage loads when empty or when the next one loads
    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || o_out.ready;
        for (int k = NST-2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // level 1 products
    logic signed [31:0] w_a1 [N1];
    logic signed [31:0] w_b1 [N1];
    logic signed [63:0] r_p1 [N1];
    logic signed [31:0] r_s0_t, r_s0_phi;

    always_comb begin
        w_a1[P1_T2]   = i_in.temperature;  w_b1[P1_T2]   = i_in.temperature;
        w_a1[P1_T02]  = r_tcrit;           w_b1[P1_T02]  = r_tcrit;
        w_a1[P1_P2]   = i_in.field_value;  w_b1[P1_P2]   = i_in.field_value;
        w_a1[P1_AT]   = r_alpha;           w_b1[P1_AT]   = i_in.temperature;
        w_a1[P1_GT]   = r_gamma;           w_b1[P1_GT]   = i_in.temperature;
        w_a1[P1_X]    = i_in.field_value;  w_b1[P1_X]    = r_recip;
        w_a1[P1_GPHI] = r_gamma;           w_b1[P1_GPHI] = i_in.field_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int i = 0; i < N1; i++) begin
                r_p1[i] <= qprod(w_a1[i], w_b1[i]);
            end
            r_s0_t   <= i_in.temperature;
            r_s0_phi <= i_in.field_value;
        end
    end

    // level 1 round
    t_qres              w_q1 [N1];
    logic [N1-1:0]      w_o1;
    logic signed [31:0] r_q1 [N1];
    logic signed [31:0] r_s1_t, r_s1_phi;

    always_comb begin
        for (int i = 0; i < N1; i++) begin
            w_q1[i] = qround(r_p1[i]);
            w_o1[i] = w_q1[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < N1; i++) begin
                r_q1[i] <= w_q1[i].val;
            end
            r_ovt[1] <= |(w_o1 & TH1);
            r_ovb[1] <= |(w_o1 & BAG1);
            r_s1_t   <= r_s0_t;
            r_s1_phi <= r_s0_phi;
        end
    end

    // clamp stage: T^2 - T0^2 and the bag shape factors
    t_qres              w_d, w_shape, w_dshape;
    logic signed [31:0] r_s2_d, r_s2_shape, r_s2_dshape;
    logic signed [31:0] r_s2_t, r_s2_phi, r_s2_t2, r_s2_p2, r_s2_at, r_s2_gt;
    logic signed [31:0] r_s2_x, r_s2_gphi;

    always_comb begin
        w_d      = qsat(64'(36'(r_q1[P1_T2]) - 36'(r_q1[P1_T02])));
        w_shape  = qsat(64'(Q_THREE - (36'(r_q1[P1_X]) <<< 1)));
        w_dshape = qsat(64'(Q_SIX - (36'(r_q1[P1_X]) <<< 2) - (36'(r_q1[P1_X]) <<< 1)));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_d      <= w_d.val;
            r_s2_shape  <= w_shape.val;
            r_s2_dshape <= w_dshape.val;
            r_ovt[2]    <= r_ovt[1] | w_d.ovf;
            r_ovb[2]    <= r_ovb[1] | w_shape.ovf | w_dshape.ovf;
            r_s2_t      <= r_s1_t;
            r_s2_phi    <= r_s1_phi;
            r_s2_t2     <= r_q1[P1_T2];
            r_s2_p2     <= r_q1[P1_P2];
            r_s2_at     <= r_q1[P1_AT];
            r_s2_gt     <= r_q1[P1_GT];
            r_s2_x      <= r_q1[P1_X];
            r_s2_gphi   <= r_q1[P1_GPHI];
        end
    end

    // level 2 products
    logic signed [31:0] w_a2 [N2];
    logic signed [31:0] w_b2 [N2];
    logic signed [63:0] r_p2 [N2];
    logic signed [31:0] r_s3_phi, r_s3_p2, r_s3_at, r_s3_t2, r_s3_shape, r_s3_dshape;
    logic signed [31:0] r_s3_gphi;

    always_comb begin
        w_a2[P2_G]    = r_gamma;   w_b2[P2_G]    = r_s2_d;
        w_a2[P2_P3]   = r_s2_p2;   w_b2[P2_P3]   = r_s2_phi;
        w_a2[P2_P4]   = r_s2_p2;   w_b2[P2_P4]   = r_s2_p2;
        w_a2[P2_GP2]  = r_gamma;   w_b2[P2_GP2]  = r_s2_p2;
        w_a2[P2_ATP2] = r_s2_at;   w_b2[P2_ATP2] = r_s2_p2;
        w_a2[P2_GTP2] = r_s2_gt;   w_b2[P2_GTP2] = r_s2_p2;
        w_a2[P2_AP2]  = r_alpha;   w_b2[P2_AP2]  = r_s2_p2;
        w_a2[P2_T3]   = r_s2_t2;   w_b2[P2_T3]   = r_s2_t;
        w_a2[P2_T4]   = r_s2_t2;   w_b2[P2_T4]   = r_s2_t2;
        w_a2[P2_X2]   = r_s2_x;    w_b2[P2_X2]   = r_s2_x;
        w_a2[P2_XR]   = r_s2_x;    w_b2[P2_XR]   = r_recip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int i = 0; i < N2; i++) begin
                r_p2[i] <= qprod(w_a2[i], w_b2[i]);
            end
            r_ovt[3]    <= r_ovt[2];
            r_ovb[3]    <= r_ovb[2];
            r_s3_phi    <= r_s2_phi;
            r_s3_p2     <= r_s2_p2;
            r_s3_at     <= r_s2_at;
            r_s3_t2     <= r_s2_t2;
            r_s3_shape  <= r_s2_shape;
            r_s3_dshape <= r_s2_dshape;
            r_s3_gphi   <= r_s2_gphi;
        end
    end

    // level 2 round
    t_qres              w_q2 [N2];
    logic [N2-1:0]      w_o2;
    logic signed [31:0] r_q2 [N2];
    logic signed [31:0] r_s4_phi, r_s4_p2, r_s4_at, r_s4_t2, r_s4_shape, r_s4_dshape;
    logic signed [31:0] r_s4_gphi;

    always_comb begin
        for (int i = 0; i < N2; i++) begin
            w_q2[i] = qround(r_p2[i]);
            w_o2[i] = w_q2[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int i = 0; i < N2; i++) begin
                r_q2[i] <= w_q2[i].val;
            end
            r_ovt[4]    <= r_ovt[3] | (|(w_o2 & TH2));
            r_ovb[4]    <= r_ovb[3] | (|(w_o2 & BAG2));
            r_s4_phi    <= r_s3_phi;
            r_s4_p2     <= r_s3_p2;
            r_s4_at     <= r_s3_at;
            r_s4_t2     <= r_s3_t2;
            r_s4_shape  <= r_s3_shape;
            r_s4_dshape <= r_s3_dshape;
            r_s4_gphi   <= r_s3_gphi;
        end
    end

    // level 3 products
    logic signed [31:0] w_a3 [N3];
    logic signed [31:0] w_b3 [N3];
    logic signed [63:0] r_p3 [N3];
    logic signed [31:0] r_s5_gp2, r_s5_atp2, r_s5_gtp2, r_s5_ap2, r_s5_t3, r_s5_t4;
    logic signed [31:0] r_s5_t2, r_s5_shape, r_s5_dshape, r_s5_gphi;

    always_comb begin
        w_a3[P3_GP2M]  = r_q2[P2_G];  w_b3[P3_GP2M]  = r_s4_p2;
        w_a3[P3_ATP3]  = r_s4_at;     w_b3[P3_ATP3]  = r_q2[P2_P3];
        w_a3[P3_LP4]   = r_lambda;    w_b3[P3_LP4]   = r_q2[P2_P4];
        w_a3[P3_LP3]   = r_lambda;    w_b3[P3_LP3]   = r_q2[P2_P3];
        w_a3[P3_AP3]   = r_alpha;     w_b3[P3_AP3]   = r_q2[P2_P3];
        w_a3[P3_GPHIT] = r_q2[P2_G];  w_b3[P3_GPHIT] = r_s4_phi;
        w_a3[P3_VX2]   = r_vacuum;    w_b3[P3_VX2]   = r_q2[P2_X2];
        w_a3[P3_VXR]   = r_vacuum;    w_b3[P3_VXR]   = r_q2[P2_XR];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int i = 0; i < N3; i++) begin
                r_p3[i] <= qprod(w_a3[i], w_b3[i]);
            end
            r_ovt[5]    <= r_ovt[4];
            r_ovb[5]    <= r_ovb[4];
            r_s5_gp2    <= r_q2[P2_GP2];
            r_s5_atp2   <= r_q2[P2_ATP2];
            r_s5_gtp2   <= r_q2[P2_GTP2];
            r_s5_ap2    <= r_q2[P2_AP2];
            r_s5_t3     <= r_q2[P2_T3];
            r_s5_t4     <= r_q2[P2_T4];
            r_s5_t2     <= r_s4_t2;
            r_s5_shape  <= r_s4_shape;
            r_s5_dshape <= r_s4_dshape;
            r_s5_gphi   <= r_s4_gphi;
        end
    end

    // level 3 round
    t_qres              w_q3 [N3];
    logic [N3-1:0]      w_o3;
    logic signed [31:0] r_q3 [N3];
    logic signed [31:0] r_s6_gp2, r_s6_atp2, r_s6_gtp2, r_s6_ap2, r_s6_t3, r_s6_t4;
    logic signed [31:0] r_s6_t2, r_s6_shape, r_s6_dshape, r_s6_gphi;

    always_comb begin
        for (int i = 0; i < N3; i++) begin
            w_q3[i] = qround(r_p3[i]);
            w_o3[i] = w_q3[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int i = 0; i < N3; i++) begin
                r_q3[i] <= w_q3[i].val;
            end
            r_ovt[6]    <= r_ovt[5] | (|(w_o3 & TH3));
            r_ovb[6]    <= r_ovb[5] | (|(w_o3 & BAG3));
            r_s6_gp2    <= r_s5_gp2;
            r_s6_atp2   <= r_s5_atp2;
            r_s6_gtp2   <= r_s5_gtp2;
            r_s6_ap2    <= r_s5_ap2;
            r_s6_t3     <= r_s5_t3;
            r_s6_t4     <= r_s5_t4;
            r_s6_t2     <= r_s5_t2;
            r_s6_shape  <= r_s5_shape;
            r_s6_dshape <= r_s5_dshape;
            r_s6_gphi   <= r_s5_gphi;
        end
    end

    // level 4 products
    logic signed [31:0] w_a4 [N4];
    logic signed [31:0] w_b4 [N4];
    logic signed [63:0] r_p4 [N4];
    logic signed [31:0] r_s7_lp3, r_s7_gphit, r_s7_gp2, r_s7_atp2, r_s7_gtp2, r_s7_ap2;
    logic signed [31:0] r_s7_t3, r_s7_t4, r_s7_t2, r_s7_gphi;

    always_comb begin
        w_a4[P4_HTH]  = r_q3[P3_GP2M];  w_b4[P4_HTH]  = Q_HALF;
        w_a4[P4_THTH] = r_q3[P3_ATP3];  w_b4[P4_THTH] = Q_THIRD;
        w_a4[P4_QU]   = r_q3[P3_LP4];   w_b4[P4_QU]   = Q_QUARTER;
        w_a4[P4_HBAG] = r_s6_gp2;       w_b4[P4_HBAG] = Q_HALF;
        w_a4[P4_AP3T] = r_q3[P3_AP3];   w_b4[P4_AP3T] = Q_THIRD;
        w_a4[P4_A]    = r_q3[P3_VX2];   w_b4[P4_A]    = r_s6_shape;
        w_a4[P4_B]    = r_q3[P3_VXR];   w_b4[P4_B]    = r_s6_dshape;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int i = 0; i < N4; i++) begin
                r_p4[i] <= qprod(w_a4[i], w_b4[i]);
            end
            r_ovt[7]   <= r_ovt[6];
            r_ovb[7]   <= r_ovb[6];
            r_s7_lp3   <= r_q3[P3_LP3];
            r_s7_gphit <= r_q3[P3_GPHIT];
            r_s7_gp2   <= r_s6_gp2;
            r_s7_atp2  <= r_s6_atp2;
            r_s7_gtp2  <= r_s6_gtp2;
            r_s7_ap2   <= r_s6_ap2;
            r_s7_t3    <= r_s6_t3;
            r_s7_t4    <= r_s6_t4;
            r_s7_t2    <= r_s6_t2;
            r_s7_gphi  <= r_s6_gphi;
        end
    end

    // level 4 round
    t_qres              w_q4 [N4];
    logic [N4-1:0]      w_o4;
    logic signed [31:0] r_q4 [N4];
    logic signed [31:0] r_s8_lp3, r_s8_gphit, r_s8_gp2, r_s8_atp2, r_s8_gtp2, r_s8_ap2;
    logic signed [31:0] r_s8_t3, r_s8_t4, r_s8_t2, r_s8_gphi;

    always_comb begin
        for (int i = 0; i < N4; i++) begin
            w_q4[i] = qround(r_p4[i]);
            w_o4[i] = w_q4[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            for (int i = 0; i < N4; i++) begin
                r_q4[i] <= w_q4[i].val;
            end
            r_ovt[8]   <= r_ovt[7] | (|(w_o4 & TH4));
            r_ovb[8]   <= r_ovb[7] | (|(w_o4 & BAG4));
            r_s8_lp3   <= r_s7_lp3;
            r_s8_gphit <= r_s7_gphit;
            r_s8_gp2   <= r_s7_gp2;
            r_s8_atp2  <= r_s7_atp2;
            r_s8_gtp2  <= r_s7_gtp2;
            r_s8_ap2   <= r_s7_ap2;
            r_s8_t3    <= r_s7_t3;
            r_s8_t4    <= r_s7_t4;
            r_s8_t2    <= r_s7_t2;
            r_s8_gphi  <= r_s7_gphi;
        end
    end

    // level 5 products: bag temperature terms
    logic signed [31:0] w_a5 [N5];
    logic signed [31:0] w_b5 [N5];
    logic signed [63:0] r_p5 [N5];
    logic signed [31:0] r_s9_hth, r_s9_thth, r_s9_qu, r_s9_hbag, r_s9_ap3t;
    logic signed [31:0] r_s9_lp3, r_s9_gphit, r_s9_gp2, r_s9_atp2, r_s9_gtp2, r_s9_ap2;
    logic signed [31:0] r_s9_gphi;

    always_comb begin
        w_a5[P5_AT4] = r_q4[P4_A];  w_b5[P5_AT4] = r_s8_t4;
        w_a5[P5_BT4] = r_q4[P4_B];  w_b5[P5_BT4] = r_s8_t4;
        w_a5[P5_T3A] = r_s8_t3;     w_b5[P5_T3A] = r_q4[P4_A];
        w_a5[P5_T2A] = r_s8_t2;     w_b5[P5_T2A] = r_q4[P4_A];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            for (int i = 0; i < N5; i++) begin
                r_p5[i] <= qprod(w_a5[i], w_b5[i]);
            end
            r_ovt[9]   <= r_ovt[8];
            r_ovb[9]   <= r_ovb[8];
            r_s9_hth   <= r_q4[P4_HTH];
            r_s9_thth  <= r_q4[P4_THTH];
            r_s9_qu    <= r_q4[P4_QU];
            r_s9_hbag  <= r_q4[P4_HBAG];
            r_s9_ap3t  <= r_q4[P4_AP3T];
            r_s9_lp3   <= r_s8_lp3;
            r_s9_gphit <= r_s8_gphit;
            r_s9_gp2   <= r_s8_gp2;
            r_s9_atp2  <= r_s8_atp2;
            r_s9_gtp2  <= r_s8_gtp2;
            r_s9_ap2   <= r_s8_ap2;
            r_s9_gphi  <= r_s8_gphi;
        end
    end

    // level 5 round
    t_qres              w_q5 [N5];
    logic [N5-1:0]      w_o5;
    logic signed [31:0] r_q5 [N5];
    logic signed [31:0] r_s10_hth, r_s10_thth, r_s10_qu, r_s10_hbag, r_s10_ap3t;
    logic signed [31:0] r_s10_lp3, r_s10_gphit, r_s10_gp2, r_s10_atp2, r_s10_gtp2;
    logic signed [31:0] r_s10_ap2, r_s10_gphi;

    always_comb begin
        for (int i = 0; i < N5; i++) begin
            w_q5[i] = qround(r_p5[i]);
            w_o5[i] = w_q5[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            for (int i = 0; i < N5; i++) begin
                r_q5[i] <= w_q5[i].val;
            end
            r_ovt[10]   <= r_ovt[9];
            r_ovb[10]   <= r_ovb[9] | (|w_o5);
            r_s10_hth   <= r_s9_hth;
            r_s10_thth  <= r_s9_thth;
            r_s10_qu    <= r_s9_qu;
            r_s10_hbag  <= r_s9_hbag;
            r_s10_ap3t  <= r_s9_ap3t;
            r_s10_lp3   <= r_s9_lp3;
            r_s10_gphit <= r_s9_gphit;
            r_s10_gp2   <= r_s9_gp2;
            r_s10_atp2  <= r_s9_atp2;
            r_s10_gtp2  <= r_s9_gtp2;
            r_s10_ap2   <= r_s9_ap2;
            r_s10_gphi  <= r_s9_gphi;
        end
    end

    // final sums, model select, output register
    logic signed [35:0] w_sum_th0, w_sum_th1, w_sum_th2;
    logic signed [35:0] w_sum_bg0, w_sum_bg1, w_sum_bg2, w_sum_bg3;
    t_qres              w_th0, w_th1, w_th2, w_bg0, w_bg1, w_bg2, w_bg3;
    logic signed [31:0] r_pot, r_dfield, r_dtemp, r_d2temp;
    logic               r_ovf;

    always_comb begin
        w_sum_th0 = 36'(r_s10_hth) - 36'(r_s10_thth) + 36'(r_s10_qu) - 36'(r_vacuum);
        w_sum_th1 = 36'(r_s10_gphit) - 36'(r_s10_atp2) + 36'(r_s10_lp3);
        w_sum_th2 = 36'(r_s10_gtp2) - 36'(r_s10_ap3t);
        w_sum_bg0 = 36'(r_s10_hbag) - 36'(r_s10_ap3t) + 36'(r_s10_qu)
                    - 36'(r_q5[P5_AT4]) - 36'(r_vacuum);
        w_sum_bg1 = 36'(r_s10_gphi) - 36'(r_s10_ap2) + 36'(r_s10_lp3)
                    - 36'(r_q5[P5_BT4]);
        w_sum_bg2 = 36'sd0 - (36'(r_q5[P5_T3A]) <<< 2);
        w_sum_bg3 = 36'sd0 - (36'(r_q5[P5_T2A]) <<< 3) - (36'(r_q5[P5_T2A]) <<< 2);
        w_th0 = qsat(64'(w_sum_th0));
        w_th1 = qsat(64'(w_sum_th1));
        w_th2 = qsat(64'(w_sum_th2));
        w_bg0 = qsat(64'(w_sum_bg0));
        w_bg1 = qsat(64'(w_sum_bg1));
        w_bg2 = qsat(64'(w_sum_bg2));
        w_bg3 = qsat(64'(w_sum_bg3));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            if (r_bag_model) begin
                r_pot    <= w_bg0.val;
                r_dfield <= w_bg1.val;
                r_dtemp  <= w_bg2.val;
                r_d2temp <= w_bg3.val;
                r_ovf    <= r_ovb[10] | w_bg0.ovf | w_bg1.ovf | w_bg2.ovf | w_bg3.ovf;
            end else begin
                r_pot    <= w_th0.val;
                r_dfield <= w_th1.val;
                r_dtemp  <= w_th2.val;
                r_d2temp <= r_s10_gp2;
                r_ovf    <= r_ovt[10] | w_th0.ovf | w_th1.ovf | w_th2.ovf;
            end
        end
    end

    assign o_out.valid    = r_v[NST-1];
    assign o_out.potential = r_pot;
    assign o_out.d_field  = r_dfield;
    assign o_out.d_temp   = r_dtemp;
    assign o_out.d2_temp  = r_d2temp;
    assign o_out.overflow = r_ovf;

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> i_in.ready)
        else $error("input stalled with first stage empty");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v[0])
        else $error("accepted transaction missing from first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_v & ~w_en) != '0) |=> ((r_v & $past(r_v & ~w_en)) == $past(r_v & ~w_en)))
        else $error("stalled stage lost its transaction");

    a_out_from_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v[NST-1]) |-> $past(r_v[NST-2]))
        else $error("output valid without a transaction in the stage before");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import spd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int END_SETTLE      = 24;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int MAX_REPORTS     = 40;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [31:0] potential;
        logic signed [31:0] d_field;
        logic signed [31:0] d_temp;
        logic signed [31:0] d2_temp;
        logic               overflow;
    } site_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SITE,
        ROW_PINNED
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         reg_idx;
        logic signed [31:0] word_a;
        logic signed [31:0] word_b;
        site_result_t       fixed;
    } stim_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    spd_in_if  in_if ();
    spd_out_if out_if ();

    scalar_potential_and_derivatives_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic signed [31:0] gam_c = '0;
    logic signed [31:0] alp_c = '0;
    logic signed [31:0] lam_c = '0;
    logic signed [31:0] v0_c  = '0;
    logic signed [31:0] tc_c  = '0;
    logic signed [31:0] rcp_c = Q_ONE;
    logic               bag_sel = 1'b0;

    bit clip_seen;

    site_result_t site_exp_q[$];
    logic         pin_flag;
    site_result_t pin_res;

    int  fault_count    = 0;
    int  sites_sent     = 0;
    int  results_seen   = 0;
    int  saturated_seen = 0;
    int  reg_writes     = 0;
    bit  free_run       = 1'b0;
    bit  hold_req       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint fx_clip(longint v);
        if (v > SAT_HI) begin
            clip_seen = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            clip_seen = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return fx_clip((a * b + RND_HALF) >>> 16);
    endfunction

    function automatic site_result_t predict_site(logic signed [31:0] temp_q,
                                                  logic signed [31:0] field_q);
        longint t, phi, t2, t3, t4, p2, p3, p4, t02, g_t, a_t;
        longint x, x2, shape, dshape, bag_a, bag_b;
        longint gm, al, la, v0, tc, rc;
        site_result_t r;
        t   = temp_q;
        phi = field_q;
        gm  = gam_c;
        al  = alp_c;
        la  = lam_c;
        v0  = v0_c;
        tc  = tc_c;
        rc  = rcp_c;
        clip_seen = 1'b0;
        t2 = fx_mul(t, t);
        p2 = fx_mul(phi, phi);
        p3 = fx_mul(p2, phi);
        p4 = fx_mul(p2, p2);
        if (!bag_sel) begin
            t02 = fx_mul(tc, tc);
            g_t = fx_mul(gm, fx_clip(t2 - t02));
            a_t = fx_mul(al, t);
            r.potential = fx_clip(fx_mul(fx_mul(g_t, p2), Q_HALF)
                                  - fx_mul(fx_mul(a_t, p3), Q_THIRD)
                                  + fx_mul(fx_mul(la, p4), Q_QUARTER)
                                  - v0);
            r.d_field   = fx_clip(fx_mul(g_t, phi) - fx_mul(a_t, p2) + fx_mul(la, p3));
            r.d_temp    = fx_clip(fx_mul(fx_mul(gm, t), p2)
                                  - fx_mul(fx_mul(al, p3), Q_THIRD));
            r.d2_temp   = fx_mul(gm, p2);
        end else begin
            t3     = fx_mul(t2, t);
            t4     = fx_mul(t2, t2);
            x      = fx_mul(phi, rc);
            x2     = fx_mul(x, x);
            shape  = fx_clip(Q_THREE - 2 * x);
            bag_a  = fx_mul(fx_mul(v0, x2), shape);
            dshape = fx_clip(Q_SIX - 6 * x);
            bag_b  = fx_mul(fx_mul(v0, fx_mul(x, rc)), dshape);
            r.potential = fx_clip(fx_mul(fx_mul(gm, p2), Q_HALF)
                                  - fx_mul(fx_mul(al, p3), Q_THIRD)
                                  + fx_mul(fx_mul(la, p4), Q_QUARTER)
                                  - fx_mul(bag_a, t4)
                                  - v0);
            r.d_field   = fx_clip(fx_mul(gm, phi) - fx_mul(al, p2)
                                  + fx_mul(la, p3) - fx_mul(bag_b, t4));
            r.d_temp    = fx_clip(-4 * fx_mul(t3, bag_a));
            r.d2_temp   = fx_clip(-12 * fx_mul(t2, bag_a));
        end
        r.overflow = clip_seen;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned pick;
        if (free_run)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        if (pick < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return -32'sd1;
            4: return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coeff(bit extremes_only);
        int unsigned pick;
        if (extremes_only)
            return pick_extreme();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom();
        if (pick == 1)
            return pick_extreme();
        return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    endfunction

    function automatic logic signed [31:0] rand_field();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick < 3)
            return $urandom();
        if (pick == 3)
            return pick_extreme();
        if (pick < 11)
            return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
        return $urandom_range(0, 32'h80_0000) - 32'h40_0000;
    endfunction

    function automatic logic signed [31:0] to_q(real x);
        return $rtoi(x * 65536.0);
    endfunction

    function automatic stim_row_t cfg_row(logic [2:0] idx, logic [31:0] val);
        stim_row_t r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.word_a  = val;
        r.word_b  = '0;
        r.fixed   = '0;
        return r;
    endfunction

    function automatic stim_row_t site_row(logic signed [31:0] temp_q,
                                           logic signed [31:0] field_q);
        stim_row_t r;
        r.kind    = ROW_SITE;
        r.reg_idx = REG_UNUSED;
        r.word_a  = temp_q;
        r.word_b  = field_q;
        r.fixed   = '0;
        return r;
    endfunction

    // all values zero, only the saturation flag differs
    function automatic stim_row_t pin_row(logic signed [31:0] temp_q,
                                          logic signed [31:0] field_q, logic ovf);
        stim_row_t r;
        r = site_row(temp_q, field_q);
        r.kind           = ROW_PINNED;
        r.fixed.overflow = ovf;
        return r;
    endfunction

    task automatic apb_park();
        if (psel) begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic apb_write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        reg_writes++;
        case (idx)
            REG_GAMMA:  gam_c   = value;
            REG_ALPHA:  alp_c   = value;
            REG_LAMBDA: lam_c   = value;
            REG_VACUUM: v0_c    = value;
            REG_TCRIT:  tc_c    = value;
            REG_RECIP:  rcp_c   = value;
            REG_MODE:   bag_sel = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_all_results();
        in_if.valid <= 1'b0;
        while (results_seen != sites_sent) @(posedge i_clk);
    endtask

    task automatic offer_site(input logic signed [31:0] temp_q,
                              input logic signed [31:0] field_q,
                              input logic pinned, input site_result_t pinned_res);
        int gap;
        apb_park();
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.temperature <= temp_q;
        in_if.field_value <= field_q;
        pin_flag          <= pinned;
        pin_res           <= pinned_res;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sites_sent++;
    endtask

    task automatic check_word(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("%0t %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        site_result_t want;
        site_result_t got;
        if (i_rst_n && in_if.valid && in_if.ready)
            site_exp_q.push_back(pin_flag ? pin_res
                                          : predict_site(in_if.temperature, in_if.field_value));
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.potential = out_if.potential;
            got.d_field   = out_if.d_field;
            got.d_temp    = out_if.d_temp;
            got.d2_temp   = out_if.d2_temp;
            got.overflow  = out_if.overflow;
            if (site_exp_q.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t result with no site pending: expected none actual %h",
                             $time, got);
            end else begin
                want = site_exp_q.pop_front();
                check_word("potential", want.potential, got.potential);
                check_word("d_field", want.d_field, got.d_field);
                check_word("d_temp", want.d_temp, got.d_temp);
                check_word("d2_temp", want.d2_temp, got.d2_temp);
                check_word("overflow", want.overflow, got.overflow);
                if (got.overflow === 1'b1)
                    saturated_seen++;
                results_seen++;
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        stim_row_t   plan[$];
        logic [31:0] mode_word;
        bit          edges;
        in_if.valid       <= 1'b0;
        in_if.temperature <= '0;
        in_if.field_value <= '0;
        pin_flag          <= 1'b0;
        pin_res           <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_rst_n           <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset values: every result value is zero, squares may still clip
        plan.push_back(pin_row('0, '0, 1'b0));
        plan.push_back(pin_row(Q_MIN, Q_MIN, 1'b1));
        plan.push_back(pin_row(Q_MAX, Q_MAX, 1'b1));
        plan.push_back(pin_row(Q_ONE, -Q_ONE, 1'b0));
        plan.push_back(pin_row(Q_MIN, '0, 1'b1));
        plan.push_back(pin_row('0, Q_MAX, 1'b1));
        // writes past the register map must leave every register alone
        plan.push_back(cfg_row(REG_UNUSED, 32'hDEAD_BEEF));
        plan.push_back(pin_row(Q_ONE, Q_ONE, 1'b0));

        plan.push_back(cfg_row(REG_GAMMA, to_q(1.5)));
        plan.push_back(cfg_row(REG_ALPHA, to_q(-0.75)));
        plan.push_back(cfg_row(REG_LAMBDA, to_q(0.5)));
        plan.push_back(cfg_row(REG_VACUUM, to_q(2.0)));
        plan.push_back(cfg_row(REG_TCRIT, to_q(3.0)));
        plan.push_back(site_row(to_q(2.0), to_q(1.0)));
        plan.push_back(site_row(to_q(-1.5), to_q(0.25)));
        plan.push_back(site_row(Q_MAX, to_q(1.0)));
        plan.push_back(site_row(to_q(0.5), Q_MIN));
        plan.push_back(site_row(-32'sd1, -32'sd1));

        plan.push_back(cfg_row(REG_GAMMA, Q_MAX));
        plan.push_back(cfg_row(REG_ALPHA, Q_MIN));
        plan.push_back(cfg_row(REG_LAMBDA, Q_MAX));
        plan.push_back(cfg_row(REG_VACUUM, Q_MIN));
        plan.push_back(cfg_row(REG_TCRIT, Q_MAX));
        plan.push_back(site_row(Q_ONE, Q_ONE));
        plan.push_back(site_row('0, '0));
        plan.push_back(site_row(Q_MIN, Q_MAX));

        // only bit 0 of the mode word counts
        plan.push_back(cfg_row(REG_MODE, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(REG_GAMMA, to_q(1.0)));
        plan.push_back(cfg_row(REG_ALPHA, to_q(0.5)));
        plan.push_back(cfg_row(REG_LAMBDA, to_q(0.25)));
        plan.push_back(cfg_row(REG_VACUUM, to_q(1.5)));
        plan.push_back(cfg_row(REG_RECIP, to_q(0.5)));
        plan.push_back(site_row(to_q(1.0), to_q(1.0)));
        plan.push_back(site_row(to_q(2.0), to_q(-2.0)));
        plan.push_back(site_row(to_q(-0.5), to_q(3.0)));
        plan.push_back(site_row(Q_MAX, Q_MIN));
        plan.push_back(site_row('0, '0));

        plan.push_back(cfg_row(REG_RECIP, Q_MIN));
        plan.push_back(cfg_row(REG_VACUUM, Q_MAX));
        plan.push_back(site_row(Q_ONE, Q_ONE));
        plan.push_back(site_row(-Q_ONE, 32'sh0000_8000));

        plan.push_back(cfg_row(REG_MODE, 32'h0000_0002));
        plan.push_back(site_row(to_q(2.0), to_q(1.0)));
        plan.push_back(site_row(Q_MIN, Q_MIN));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_all_results();
                apb_write_reg(plan[i].reg_idx, plan[i].word_a);
            end else begin
                offer_site(plan[i].word_a, plan[i].word_b,
                           plan[i].kind == ROW_PINNED, plan[i].fixed);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_all_results();
            edges     = (ph == 7);
            mode_word = $urandom();
            mode_word[0] = ph[0];
            apb_write_reg(REG_GAMMA, rand_coeff(edges));
            apb_write_reg(REG_ALPHA, rand_coeff(edges));
            apb_write_reg(REG_LAMBDA, rand_coeff(edges));
            apb_write_reg(REG_VACUUM, rand_coeff(edges));
            apb_write_reg(REG_TCRIT, rand_coeff(edges));
            apb_write_reg(REG_RECIP, rand_coeff(edges));
            apb_write_reg(REG_MODE, mode_word);
            free_run = (ph == 2);
            if (ph == 4)
                hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 6 && k == ITEMS_PER_PHASE / 2)
                    wait_all_results();
                offer_site(rand_field(), rand_field(), 1'b0, '0);
            end
        end
        free_run = 1'b0;

        wait_all_results();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("%0d site results checked over %0d register writes, %0d of them saturated",
                 results_seen, sites_sent == results_seen ? reg_writes : reg_writes,
                 saturated_seen);
        $display("both models, register extremes, a long output hold and a full drain covered");
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
design/spd_pkg.sv
design/spd_in_if.sv
design/spd_out_if.sv
design/scalar_potential_and_derivatives_top.sv
tb/sv/tb_top.sv
